// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define HLCC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// next-cycle implication, disabled while reset is asserted
`define HLCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// ----- hdl/hlcc_pkg.sv -----
// ----------------------------------------------------------------------------
// hlcc_pkg
// Types, constants and functions of the hex line CRC checker.
// ----------------------------------------------------------------------------
`default_nettype none

package hlcc_pkg;

    localparam int          CRC_W            = 32;
    localparam logic [31:0] CRC_INIT         = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY         = 32'h04C1_1DB7;
    localparam logic [31:0] CRC_TOP          = 32'h8000_0000;

    localparam logic [7:0]  CHAR_CR          = 8'h0D;
    localparam logic [7:0]  CHAR_ZERO        = 8'h30;
    localparam logic [7:0]  CHAR_NINE        = 8'h39;
    localparam logic [7:0]  CHAR_A           = 8'h41;
    localparam logic [7:0]  CHAR_F           = 8'h46;
    localparam logic [7:0]  HEX_ALPHA_OFFSET = 8'd10;

    localparam int          HELD_DEPTH       = 4;
    localparam int          QUEUE_DEPTH      = 4;
    localparam int          QUEUE_PTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        TOK_BYTE = 2'd0,
        TOK_BAD  = 2'd1,
        TOK_EOL  = 2'd2
    } t_tok_kind;

    typedef struct packed {
        t_tok_kind  kind;
        logic [7:0] data;
    } t_tok;

    typedef struct packed {
        logic valid;
        t_tok tok;
    } t_tok_xfer;

    // {is_digit, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] ch);
        logic [7:0] alpha;
        alpha = ch - CHAR_A + HEX_ALPHA_OFFSET;
        if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
            return {1'b1, ch[3:0]};
        end else if (ch >= CHAR_A && ch <= CHAR_F) begin
            return {1'b1, alpha[3:0]};
        end
        return 5'd0;
    endfunction

    // MSB-first CRC-32 over one word, folded into an XOR network
    function automatic logic [31:0] crc_word(input logic [31:0] crc, input logic [31:0] w);
        logic [31:0] c;
        c = crc ^ w;
        for (int k = 0; k < CRC_W; k++) begin
            if ((c & CRC_TOP) != 32'd0) begin
                c = (c << 1) ^ CRC_POLY;
            end else begin
                c = c << 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/hlcc_front.sv -----
// ----------------------------------------------------------------------------
// hlcc_front
// Character front end: skips the character after a carriage return, pairs
// hex digits into byte tokens and makes a token of each non-hex character.
// ----------------------------------------------------------------------------
`default_nettype none

module hlcc_front
    import hlcc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic [7:0] i_char_in,
    input  wire logic       i_queue_full,
    output t_tok_xfer       o_push
);

    logic       r_skip;
    logic       r_pend;
    logic [3:0] r_high;
    logic       n_skip;
    logic       n_pend;
    logic [3:0] n_high;
    logic       accept;
    logic [4:0] digit;

    assign accept = i_in_valid && !i_queue_full;
    assign digit  = hex_digit(i_char_in);

    always_comb begin
        n_skip          = r_skip;
        n_pend          = r_pend;
        n_high          = r_high;
        o_push.valid    = 1'b0;
        o_push.tok.kind = TOK_BAD;
        o_push.tok.data = 8'd0;
        if (accept) begin
            if (r_skip) begin
                n_skip = 1'b0;
            end else if (i_char_in == CHAR_CR) begin
                o_push.valid    = 1'b1;
                o_push.tok.kind = TOK_EOL;
                n_skip          = 1'b1;
                n_pend          = 1'b0;
                n_high          = 4'd0;
            end else if (!digit[4]) begin
                o_push.valid    = 1'b1;
                o_push.tok.kind = TOK_BAD;
            end else if (!r_pend) begin
                n_high = digit[3:0];
                n_pend = 1'b1;
            end else begin
                o_push.valid    = 1'b1;
                o_push.tok.kind = TOK_BYTE;
                o_push.tok.data = {r_high, digit[3:0]};
                n_pend          = 1'b0;
                n_high          = 4'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip <= 1'b0;
            r_pend <= 1'b0;
            r_high <= 4'd0;
        end else begin
            r_skip <= n_skip;
            r_pend <= n_pend;
            r_high <= n_high;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/hlcc_queue.sv -----
// ----------------------------------------------------------------------------
// hlcc_queue
// Short token queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module hlcc_queue
    import hlcc_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_tok_xfer i_push,
    input  wire logic      i_pop,
    output logic           o_full,
    output t_tok_xfer      o_head
);

    t_tok                   r_slot [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_PTR_W:0]   r_count;
    logic                   do_push;
    logic                   do_pop;

    assign o_full      = (r_count == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.tok   = r_slot[r_rd_ptr];
    assign do_push      = i_push.valid && !o_full;
    assign do_pop       = i_pop && o_head.valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_push.tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- hdl/hlcc_back.sv -----
// ----------------------------------------------------------------------------
// hlcc_back
// Token back end: four-byte hold line, little-endian word packing, CRC-32
// update, line verdict and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hlcc_back
    import hlcc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_tok_xfer  i_head,
    output logic            o_pop,
    input  wire logic       i_out_stall,
    output logic            o_out_valid,
    output logic [7:0]      o_data_byte,
    output logic            o_is_verdict,
    output logic            o_line_ok
);

    logic [31:0] r_crc;
    logic [7:0]  r_held [HELD_DEPTH];
    logic [2:0]  r_held_count;
    logic [23:0] r_accum;
    logic [1:0]  r_fill;
    logic        r_hex_err;
    logic        r_out_valid;
    logic [7:0]  r_data;
    logic        r_verdict;
    logic        r_ok;

    logic [31:0] n_crc;
    logic [7:0]  n_held [HELD_DEPTH];
    logic [2:0]  n_held_count;
    logic [23:0] n_accum;
    logic [1:0]  n_fill;
    logic        n_hex_err;
    logic        n_out_valid;
    logic        n_load;
    logic [7:0]  n_data;
    logic        n_verdict;
    logic        n_ok;

    logic        take;
    logic [31:0] crc_in;
    logic [31:0] crc_next;
    logic [31:0] crc_final;
    logic [31:0] tail;

    assign take  = i_head.valid && (!r_out_valid || !i_out_stall);
    assign o_pop = take;

    assign crc_in    = (i_head.tok.kind == TOK_EOL) ? {8'd0, r_accum}
                                                     : {r_held[0], r_accum};
    assign crc_next  = crc_word(r_crc, crc_in);
    assign crc_final = (r_fill != 2'd0) ? crc_next : r_crc;
    assign tail      = {r_held[3], r_held[2], r_held[1], r_held[0]};

    always_comb begin
        n_crc        = r_crc;
        n_held       = r_held;
        n_held_count = r_held_count;
        n_accum      = r_accum;
        n_fill       = r_fill;
        n_hex_err    = r_hex_err;
        n_out_valid  = r_out_valid && i_out_stall;
        n_load       = 1'b0;
        n_data       = 8'd0;
        n_verdict    = 1'b0;
        n_ok         = 1'b0;
        if (take) begin
            unique case (i_head.tok.kind)
                TOK_BAD: begin
                    n_hex_err = 1'b1;
                end
                TOK_BYTE: begin
                    if (!r_held_count[2]) begin
                        n_held[r_held_count[1:0]] = i_head.tok.data;
                        n_held_count              = r_held_count + 3'd1;
                    end else begin
                        n_held[0]   = r_held[1];
                        n_held[1]   = r_held[2];
                        n_held[2]   = r_held[3];
                        n_held[3]   = i_head.tok.data;
                        n_out_valid = 1'b1;
                        n_load      = 1'b1;
                        n_data      = r_held[0];
                        case (r_fill)
                            2'd0: begin
                                n_accum[7:0] = r_held[0];
                                n_fill       = 2'd1;
                            end
                            2'd1: begin
                                n_accum[15:8] = r_held[0];
                                n_fill        = 2'd2;
                            end
                            2'd2: begin
                                n_accum[23:16] = r_held[0];
                                n_fill         = 2'd3;
                            end
                            default: begin
                                n_crc   = crc_next;
                                n_accum = 24'd0;
                                n_fill  = 2'd0;
                            end
                        endcase
                    end
                end
                TOK_EOL: begin
                    n_out_valid  = 1'b1;
                    n_load       = 1'b1;
                    n_verdict    = 1'b1;
                    n_ok         = !r_hex_err && r_held_count[2] && (tail == crc_final);
                    n_crc        = CRC_INIT;
                    n_held_count = 3'd0;
                    n_accum      = 24'd0;
                    n_fill       = 2'd0;
                    n_hex_err    = 1'b0;
                end
                default: begin
                    n_hex_err = r_hex_err;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc        <= CRC_INIT;
            r_held_count <= 3'd0;
            r_accum      <= 24'd0;
            r_fill       <= 2'd0;
            r_hex_err    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_crc        <= n_crc;
            r_held_count <= n_held_count;
            r_accum      <= n_accum;
            r_fill       <= n_fill;
            r_hex_err    <= n_hex_err;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_held <= n_held;
        if (n_load) begin
            r_data    <= n_data;
            r_verdict <= n_verdict;
            r_ok      <= n_ok;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_data_byte  = r_data;
    assign o_is_verdict = r_verdict;
    assign o_line_ok    = r_ok;

endmodule

`default_nettype wire

// ----- hdl/hex_line_crc_checker_top.sv -----
// ----------------------------------------------------------------------------
// hex_line_crc_checker_top
// Hex text line checker with CRC-32 verdict per line.
// ----------------------------------------------------------------------------
// Takes one character per cycle with no gaps of its own: the front end
// classifies the character in the cycle it is accepted and writes a token
// into a four-entry queue; the back end retires one token per cycle, while
// its output is empty or not stalled, into a single output register. Input
// stall rises only while the queue is full. Each line yields its data bytes
// four positions late and one verdict item at the carriage return; the
// character after it is skipped.
// ----------------------------------------------------------------------------
`default_nettype none

module hex_line_crc_checker_top
    import hlcc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_char_in,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_data_byte,
    output logic            o_is_verdict,
    output logic            o_line_ok
);

    t_tok_xfer push;
    t_tok_xfer head;
    logic      queue_full;
    logic      pop;

    assign o_in_stall = queue_full;

    hlcc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_char_in    (i_char_in),
        .i_queue_full (queue_full),
        .o_push       (push)
    );

    hlcc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (queue_full),
        .o_head  (head)
    );

    hlcc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .o_pop        (pop),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_data_byte  (o_data_byte),
        .o_is_verdict (o_is_verdict),
        .o_line_ok    (o_line_ok)
    );

endmodule

`default_nettype wire

// ----- hdl/hlcc_checker.sv -----
// ----------------------------------------------------------------------------
// hlcc_checker
// Port-level checks of the hex line CRC checker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module hlcc_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_stall,
    input wire logic [7:0] i_char_in,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic [7:0] o_data_byte,
    input wire logic       o_is_verdict,
    input wire logic       o_line_ok
);

    logic       in_wait;
    logic       out_wait;
    logic       out_verdict;
    logic       out_data;
    logic [9:0] out_bus;

    assign in_wait     = i_in_valid && o_in_stall;
    assign out_wait    = o_out_valid && i_out_stall;
    assign out_verdict = o_out_valid && o_is_verdict;
    assign out_data    = o_out_valid && !o_is_verdict;
    assign out_bus     = {o_data_byte, o_is_verdict, o_line_ok};

    `HLCC_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, in_wait, i_in_valid && $stable(i_char_in))
    `HLCC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_wait, o_out_valid && $stable(out_bus))
    `HLCC_ASSERT_IMPL(a_verdict_no_data, i_clk, i_rst_n, out_verdict, o_data_byte == 8'd0)
    `HLCC_ASSERT_IMPL(a_data_not_ok, i_clk, i_rst_n, out_data, !o_line_ok)
    `HLCC_ASSERT_IMPL(a_reset_quiet, i_clk, i_rst_n, !$past(i_rst_n), !o_out_valid && !o_in_stall)

endmodule

bind hex_line_crc_checker_top hlcc_checker u_checker (.*);

`default_nettype wire
